// ----- rtl/websocket_frame_deframer_unmask_defines.svh -----
// ----------------------------------------------------------------------------
// WebSocket deframer assertion macros
// Shared concurrent assertion forms, clocked on clk_i and off during reset.
// ----------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_DEFRAMER_UNMASK_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_UNMASK_DEFINES_SVH

// Same-cycle implication.
`define WSDU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define WSDU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/wsdu_pkg.sv -----
// ----------------------------------------------------------------------------
// WebSocket deframer package
// Types, field widths, protocol constants and the length check function.
// ----------------------------------------------------------------------------
`default_nettype none

package wsdu_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned LenW      = 31;
  localparam int unsigned OpW       = 4;
  localparam int unsigned KeyW      = 32;
  localparam int unsigned CntW      = 3;
  localparam int unsigned OutTdataW = 48;
  localparam int unsigned OutTuserW = 2;

  // Queue between parser and output stage; depth must be a power of two.
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic [LenW-1:0] MaxLenReset = 31'd2147483633;
  localparam logic [LenW-1:0] LenCtrlMax  = 31'd125;
  localparam logic [6:0]      LenExt16    = 7'd126;
  localparam logic [6:0]      LenExt64    = 7'd127;
  localparam logic [CntW-1:0] Ext16Bytes  = 3'd2;
  localparam logic [CntW-1:0] Ext64Wrap   = 3'd0;
  localparam logic [CntW-1:0] KeyLastCnt  = 3'd3;

  localparam logic [OpW-1:0] OpCont  = 4'h0;
  localparam logic [OpW-1:0] OpText  = 4'h1;
  localparam logic [OpW-1:0] OpBin   = 4'h2;
  localparam logic [OpW-1:0] OpClose = 4'h8;
  localparam logic [OpW-1:0] OpPing  = 4'h9;
  localparam logic [OpW-1:0] OpPong  = 4'hA;

  typedef enum logic [2:0] {
    PhHdr0,
    PhHdr1,
    PhExtLen,
    PhMask,
    PhPayload
  } phase_e;

  typedef enum logic [1:0] {
    KindHeader = 2'd0,
    KindData   = 2'd1,
    KindError  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ErrReserved = 3'd0,
    ErrUnmasked = 3'd1,
    ErrTooLong  = 3'd2,
    ErrOpcode   = 3'd3,
    ErrControl  = 3'd4
  } err_code_e;

  typedef struct packed {
    logic      err;
    err_code_e code;
  } chk_t;

  // One result request as the parser classifies it; the byte is still masked.
  typedef struct packed {
    kind_e            kind;
    logic             fin;
    logic [OpW-1:0]   opcode;
    logic [LenW-1:0]  plen;
    logic [ByteW-1:0] raw;
    logic [ByteW-1:0] key;
    logic             last;
    err_code_e        err;
  } item_t;

  function automatic logic opcode_known(logic [OpW-1:0] op);
    return (op == OpCont) || (op == OpText) || (op == OpBin) ||
           (op == OpClose) || (op == OpPing) || (op == OpPong);
  endfunction

  // big marks a length of 2^31 or more.
  function automatic chk_t len_check(logic [LenW-1:0] len, logic big,
                                     logic [LenW-1:0] max_len,
                                     logic [OpW-1:0] op, logic fin);
    chk_t r;
    r.err  = 1'b1;
    r.code = ErrTooLong;
    if (big || (len > max_len)) begin
      r.code = ErrTooLong;
    end else if (!opcode_known(op)) begin
      r.code = ErrOpcode;
    end else if (op[OpW-1] && (!fin || (len > LenCtrlMax))) begin
      r.code = ErrControl;
    end else begin
      r.err  = 1'b0;
      r.code = ErrReserved;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/wsdu_parser.sv -----
// ----------------------------------------------------------------------------
// WebSocket deframer front end
// Accepts frame bytes, walks the header, length and key fields and pushes one
// classified result request per byte that yields a result.
// ----------------------------------------------------------------------------
`default_nettype none
`include "websocket_frame_deframer_unmask_defines.svh"

module wsdu_parser (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire  [wsdu_pkg::LenW-1:0]        cfg_wdata_i,
  input  wire                              in_valid_i,
  output logic                             in_ready_o,
  input  wire  [wsdu_pkg::ByteW-1:0]       in_byte_i,
  input  wire                              q_full_i,
  output logic                             push_o,
  output wsdu_pkg::item_t                  item_o
);

  wsdu_pkg::phase_e               phase_q, phase_d;
  logic [wsdu_pkg::CntW-1:0]      cnt_q, cnt_d;
  logic                           fin_q, fin_d;
  logic [wsdu_pkg::OpW-1:0]       op_q, op_d;
  logic [wsdu_pkg::LenW-1:0]      acc_q, acc_d;
  logic                           big_q, big_d;
  logic [wsdu_pkg::KeyW-1:0]      key_q, key_d;
  logic [wsdu_pkg::LenW-1:0]      idx_q, idx_d;
  logic                           halted_q, halted_d;
  logic                           ext64_q, ext64_d;
  logic [wsdu_pkg::LenW-1:0]      max_len_q;

  logic                           fire;
  logic [wsdu_pkg::ByteW-1:0]     b;
  logic                           rsv_bad;
  logic                           unmasked;
  logic                           is_ext;
  logic [wsdu_pkg::CntW-1:0]      cnt_inc;
  logic                           ext_done;
  logic [wsdu_pkg::LenW-1:0]      ext_len;
  logic                           ext_big;
  logic [wsdu_pkg::LenW-1:0]      chk_len;
  logic                           chk_big;
  wsdu_pkg::chk_t                 chk;
  logic                           key_done;
  logic                           pay_last;
  logic [wsdu_pkg::ByteW-1:0]     key_byte;
  logic                           err_push;

  assign in_ready_o = !q_full_i;
  assign fire       = in_valid_i && in_ready_o && !halted_q;
  assign b          = in_byte_i;
  assign err_push   = push_o && (item_o.kind == wsdu_pkg::KindError);

  // Field decode shared by the state and datapath blocks.
  always_comb begin
    rsv_bad  = |b[6:4];
    unmasked = !b[7];
    is_ext   = (b[6:0] == wsdu_pkg::LenExt16) || (b[6:0] == wsdu_pkg::LenExt64);
    cnt_inc  = cnt_q + 3'd1;
    ext_done = ext64_q ? (cnt_inc == wsdu_pkg::Ext64Wrap) : (cnt_inc == wsdu_pkg::Ext16Bytes);
    ext_len  = {acc_q[wsdu_pkg::LenW-wsdu_pkg::ByteW-1:0], b};
    ext_big  = big_q || (|acc_q[wsdu_pkg::LenW-1:wsdu_pkg::LenW-wsdu_pkg::ByteW]);
    if (phase_q == wsdu_pkg::PhHdr1) begin
      chk_len = {24'd0, b[6:0]};
      chk_big = 1'b0;
    end else begin
      chk_len = ext_len;
      chk_big = ext_big;
    end
    chk      = wsdu_pkg::len_check(chk_len, chk_big, max_len_q, op_q, fin_q);
    key_done = (cnt_q == wsdu_pkg::KeyLastCnt);
    pay_last = (({1'b0, idx_q} + 32'd1) >= {1'b0, acc_q});
    unique case (idx_q[1:0])
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  // Next state.
  always_comb begin
    phase_d = phase_q;
    if (fire) begin
      unique case (phase_q)
        wsdu_pkg::PhHdr0: begin
          if (!rsv_bad) phase_d = wsdu_pkg::PhHdr1;
        end
        wsdu_pkg::PhHdr1: begin
          if (!unmasked) begin
            if (is_ext) phase_d = wsdu_pkg::PhExtLen;
            else if (!chk.err) phase_d = wsdu_pkg::PhMask;
          end
        end
        wsdu_pkg::PhExtLen: begin
          if (ext_done && !chk.err) phase_d = wsdu_pkg::PhMask;
        end
        wsdu_pkg::PhMask: begin
          if (key_done) begin
            phase_d = (acc_q == '0) ? wsdu_pkg::PhHdr0 : wsdu_pkg::PhPayload;
          end
        end
        wsdu_pkg::PhPayload: begin
          if (pay_last) phase_d = wsdu_pkg::PhHdr0;
        end
        default: phase_d = wsdu_pkg::PhHdr0;
      endcase
    end
  end

  // Datapath and result requests.
  always_comb begin
    cnt_d    = cnt_q;
    fin_d    = fin_q;
    op_d     = op_q;
    acc_d    = acc_q;
    big_d    = big_q;
    key_d    = key_q;
    idx_d    = idx_q;
    halted_d = halted_q;
    ext64_d  = ext64_q;
    push_o   = 1'b0;
    item_o   = '0;
    if (fire) begin
      unique case (phase_q)
        wsdu_pkg::PhHdr0: begin
          if (rsv_bad) begin
            push_o      = 1'b1;
            item_o.kind = wsdu_pkg::KindError;
            item_o.err  = wsdu_pkg::ErrReserved;
          end else begin
            fin_d = b[7];
            op_d  = b[3:0];
          end
        end
        wsdu_pkg::PhHdr1: begin
          if (unmasked) begin
            push_o      = 1'b1;
            item_o.kind = wsdu_pkg::KindError;
            item_o.err  = wsdu_pkg::ErrUnmasked;
          end else begin
            cnt_d = '0;
            key_d = '0;
            idx_d = '0;
            big_d = 1'b0;
            if (is_ext) begin
              acc_d   = '0;
              ext64_d = (b[6:0] == wsdu_pkg::LenExt64);
            end else begin
              acc_d = chk_len;
              if (chk.err) begin
                push_o      = 1'b1;
                item_o.kind = wsdu_pkg::KindError;
                item_o.err  = chk.code;
              end
            end
          end
        end
        wsdu_pkg::PhExtLen: begin
          acc_d = ext_len;
          big_d = ext_big;
          cnt_d = cnt_inc;
          if (ext_done) begin
            cnt_d = '0;
            if (chk.err) begin
              push_o      = 1'b1;
              item_o.kind = wsdu_pkg::KindError;
              item_o.err  = chk.code;
            end
          end
        end
        wsdu_pkg::PhMask: begin
          key_d = {key_q[wsdu_pkg::KeyW-wsdu_pkg::ByteW-1:0], b};
          cnt_d = cnt_inc;
          if (key_done) begin
            cnt_d         = '0;
            idx_d         = '0;
            push_o        = 1'b1;
            item_o.kind   = wsdu_pkg::KindHeader;
            item_o.fin    = fin_q;
            item_o.opcode = op_q;
            item_o.plen   = acc_q;
            item_o.last   = (acc_q == '0);
          end
        end
        wsdu_pkg::PhPayload: begin
          push_o        = 1'b1;
          item_o.kind   = wsdu_pkg::KindData;
          item_o.fin    = fin_q;
          item_o.opcode = op_q;
          item_o.plen   = acc_q;
          item_o.raw    = b;
          item_o.key    = key_byte;
          item_o.last   = pay_last;
          idx_d         = pay_last ? '0 : (idx_q + 31'd1);
        end
        default: ;
      endcase
      // Any error freezes the parser until reset.
      if (push_o && (item_o.kind == wsdu_pkg::KindError)) halted_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= wsdu_pkg::PhHdr0;
      cnt_q     <= '0;
      fin_q     <= 1'b0;
      op_q      <= '0;
      acc_q     <= '0;
      big_q     <= 1'b0;
      key_q     <= '0;
      idx_q     <= '0;
      halted_q  <= 1'b0;
      ext64_q   <= 1'b0;
      max_len_q <= wsdu_pkg::MaxLenReset;
    end else begin
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      fin_q    <= fin_d;
      op_q     <= op_d;
      acc_q    <= acc_d;
      big_q    <= big_d;
      key_q    <= key_d;
      idx_q    <= idx_d;
      halted_q <= halted_d;
      ext64_q  <= ext64_d;
      if (cfg_we_i) max_len_q <= cfg_wdata_i;
    end
  end

  `WSDU_ASSERT_NEXT(a_halt_sticky, halted_q, halted_q, "parser left the halted state")
  `WSDU_ASSERT_NEXT(a_err_halts, err_push, halted_q, "error request did not halt the parser")
  `WSDU_ASSERT_NOW(a_pay_live, phase_q == wsdu_pkg::PhPayload, !halted_q, "halted in payload")
  `WSDU_ASSERT_NOW(a_push_when_room, push_o, !q_full_i, "request pushed into a full queue")

endmodule

`default_nettype wire

// ----- rtl/wsdu_queue.sv -----
// ----------------------------------------------------------------------------
// WebSocket deframer request queue
// Small register FIFO between the parser and the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module wsdu_queue (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push_i,
  input  wsdu_pkg::item_t     item_i,
  output logic                full_o,
  input  wire                 pop_i,
  output logic                valid_o,
  output wsdu_pkg::item_t     item_o
);

  wsdu_pkg::item_t              mem_q [wsdu_pkg::QDepth];
  logic [wsdu_pkg::QPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [wsdu_pkg::QPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [wsdu_pkg::QCntW-1:0]   count_q, count_d;
  logic                         do_push;
  logic                         do_pop;

  assign full_o  = (count_q == wsdu_pkg::QCntW'(wsdu_pkg::QDepth));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? (wr_ptr_q + 1'b1) : wr_ptr_q;
    rd_ptr_d = do_pop  ? (rd_ptr_q + 1'b1) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) count_d = count_q + 1'b1;
    else if (!do_push && do_pop) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= item_i;
  end

endmodule

`default_nettype wire

// ----- rtl/wsdu_emit.sv -----
// ----------------------------------------------------------------------------
// WebSocket deframer back end
// Pops requests, unmasks payload bytes and holds the result on the master
// stream until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module wsdu_emit (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                q_valid_i,
  input  wsdu_pkg::item_t                    q_item_i,
  output logic                               q_pop_o,
  output logic                               m_valid_o,
  input  wire                                m_ready_i,
  output logic [wsdu_pkg::OutTdataW-1:0]     m_data_o,
  output logic [wsdu_pkg::OutTuserW-1:0]     m_user_o,
  output logic                               m_last_o
);

  logic                               valid_q, valid_d;
  logic [wsdu_pkg::OutTdataW-1:0]     data_q, data_d;
  logic [wsdu_pkg::OutTuserW-1:0]     user_q, user_d;
  logic                               last_q, last_d;

  assign q_pop_o = q_valid_i && (!valid_q || m_ready_i);

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    user_d  = user_q;
    last_d  = last_q;
    if (q_pop_o) begin
      valid_d = 1'b1;
      data_d  = {1'b0, q_item_i.err, q_item_i.raw ^ q_item_i.key, q_item_i.plen,
                 q_item_i.opcode, q_item_i.fin};
      user_d  = q_item_i.kind;
      last_d  = q_item_i.last;
    end else if (m_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    user_q <= user_d;
    last_q <= last_d;
  end

  assign m_valid_o = valid_q;
  assign m_data_o  = data_q;
  assign m_user_o  = user_q;
  assign m_last_o  = last_q;

endmodule

`default_nettype wire

// ----- rtl/websocket_frame_deframer_unmask.sv -----
// ----------------------------------------------------------------------------
// WebSocket client frame deframer and unmasker
// Parses client frames one byte a cycle unless stalled, and streams out
// headers, unmasked payload bytes and protocol errors.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one received frame byte per request in s_axis_tdata.
//   m_axis carries one result per request: tuser is the kind (header,
//   payload byte, error), tlast marks the final payload byte or the header
//   of an empty frame. Header fields, unmasked byte and error code are
//   packed in m_axis_tdata.
//   cfg_wr_en_i / cfg_wr_data_i set the largest accepted payload length;
//   write it only while the block is idle.
// Path: a result is queued when its byte is taken, then loaded from the
//   queue into the output register once that register is empty or being taken.
// Throughput: one byte per cycle while s_axis_tready is high.
// Reset: parser waits for a first header byte, queue and output empty,
//   length limit back to 2147483633.
// Stall: when m_axis_tready is low the output register and the two-entry
//   queue fill, then s_axis_tready drops until room is made.
// After a protocol error one error result is sent and all later bytes are
//   taken and dropped until reset.
// ----------------------------------------------------------------------------
`default_nettype none

module websocket_frame_deframer_unmask (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                cfg_wr_en_i,
  input  wire  [wsdu_pkg::LenW-1:0]          cfg_wr_data_i,
  input  wire                                s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire  [wsdu_pkg::ByteW-1:0]         s_axis_tdata,   // [7:0] rx_byte
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  // [0] fin, [4:1] opcode, [35:5] payload_length, [43:36] data,
  // [46:44] error_code, [47] zero
  output logic [wsdu_pkg::OutTdataW-1:0]     m_axis_tdata,
  output logic [wsdu_pkg::OutTuserW-1:0]     m_axis_tuser,   // [1:0] kind
  output logic                               m_axis_tlast
);

  logic             push;
  wsdu_pkg::item_t  push_item;
  logic             q_full;
  logic             q_valid;
  logic             q_pop;
  wsdu_pkg::item_t  q_item;

  wsdu_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_wr_en_i),
    .cfg_wdata_i (cfg_wr_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .q_full_i    (q_full),
    .push_o      (push),
    .item_o      (push_item)
  );

  wsdu_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  wsdu_emit u_emit (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_item_i  (q_item),
    .q_pop_o   (q_pop),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (m_axis_tdata),
    .m_user_o  (m_axis_tuser),
    .m_last_o  (m_axis_tlast)
  );

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// WebSocket deframer testbench
// Streams client frames into the deframer with random gaps and back-pressure,
// tracks the expected headers, unmasked payload bytes and the protocol error
// in a frame-tracking predictor, and checks every result in order. The length
// limit is changed between frame batches; the run closes with one protocol
// error and 20 bytes that must be dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

  typedef struct packed {
    wsdu_pkg::kind_e                kind;
    logic                           fin;
    logic [wsdu_pkg::OpW-1:0]       opcode;
    logic [wsdu_pkg::LenW-1:0]      plen;
    logic [wsdu_pkg::ByteW-1:0]     data;
    logic                           last;
    wsdu_pkg::err_code_e            code;
  } ws_result_t;

  typedef enum int {EncShort, Enc16, Enc64} len_enc_e;

  // Follows the frame parser byte by byte and queues the results it owes.
  class frame_tracker;
    logic [wsdu_pkg::LenW-1:0] max_len;
    wsdu_pkg::phase_e          ph;
    logic [2:0]                cnt;
    logic                      fin_q;
    logic [wsdu_pkg::OpW-1:0]  op_q;
    logic [63:0]               len_q;
    logic [31:0]               key_q;
    logic [wsdu_pkg::LenW-1:0] idx_q;
    logic                      halted;
    logic                      ext64;
    ws_result_t                due_results[$];
    int                        failures;
    int                        shown;

    function new();
      max_len  = wsdu_pkg::MaxLenReset;
      ph       = wsdu_pkg::PhHdr0;
      cnt      = '0;
      fin_q    = 1'b0;
      op_q     = '0;
      len_q    = '0;
      key_q    = '0;
      idx_q    = '0;
      halted   = 1'b0;
      ext64    = 1'b0;
      failures = 0;
      shown    = 0;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    function void raise_error(wsdu_pkg::err_code_e c);
      ws_result_t r;
      r      = '0;
      r.kind = wsdu_pkg::KindError;
      r.code = c;
      halted = 1'b1;
      due_results.push_back(r);
    endfunction

    // Run the checks once the length is complete, in protocol order.
    function void close_length();
      logic known;
      case (op_q)
        wsdu_pkg::OpCont, wsdu_pkg::OpText, wsdu_pkg::OpBin,
        wsdu_pkg::OpClose, wsdu_pkg::OpPing, wsdu_pkg::OpPong: known = 1'b1;
        default: known = 1'b0;
      endcase
      if (len_q > {33'd0, max_len}) begin
        raise_error(wsdu_pkg::ErrTooLong);
      end else if (!known) begin
        raise_error(wsdu_pkg::ErrOpcode);
      end else if (op_q[3] && (!fin_q || len_q > 64'd125)) begin
        raise_error(wsdu_pkg::ErrControl);
      end else begin
        ph = wsdu_pkg::PhMask;
      end
    endfunction

    function void take_byte(logic [wsdu_pkg::ByteW-1:0] b);
      ws_result_t r;
      logic [7:0] kb;
      if (halted) return;
      r = '0;
      case (ph)
        wsdu_pkg::PhHdr0: begin
          if (b[6:4] != 3'b000) begin
            raise_error(wsdu_pkg::ErrReserved);
          end else begin
            fin_q = b[7];
            op_q  = b[3:0];
            ph    = wsdu_pkg::PhHdr1;
          end
        end
        wsdu_pkg::PhHdr1: begin
          if (!b[7]) begin
            raise_error(wsdu_pkg::ErrUnmasked);
          end else begin
            cnt   = '0;
            key_q = '0;
            idx_q = '0;
            len_q = '0;
            if (b[6:0] == wsdu_pkg::LenExt16 || b[6:0] == wsdu_pkg::LenExt64) begin
              ext64 = (b[6:0] == wsdu_pkg::LenExt64);
              ph    = wsdu_pkg::PhExtLen;
            end else begin
              len_q = {57'd0, b[6:0]};
              close_length();
            end
          end
        end
        wsdu_pkg::PhExtLen: begin
          len_q = {len_q[55:0], b};
          cnt   = cnt + 3'd1;
          // 64-bit length ends when the 3-bit count wraps
          if (cnt == (ext64 ? 3'd0 : 3'd2)) begin
            cnt = '0;
            close_length();
          end
        end
        wsdu_pkg::PhMask: begin
          key_q = {key_q[23:0], b};
          cnt   = cnt + 3'd1;
          if (cnt == 3'd4) begin
            cnt      = '0;
            idx_q    = '0;
            r.kind   = wsdu_pkg::KindHeader;
            r.fin    = fin_q;
            r.opcode = op_q;
            r.plen   = len_q[wsdu_pkg::LenW-1:0];
            r.last   = (len_q == 64'd0);
            if (len_q == 64'd0) begin
              ph = wsdu_pkg::PhHdr0;
            end else begin
              ph = wsdu_pkg::PhPayload;
            end
            due_results.push_back(r);
          end
        end
        wsdu_pkg::PhPayload: begin
          case (idx_q[1:0])
            2'd0:    kb = key_q[31:24];
            2'd1:    kb = key_q[23:16];
            2'd2:    kb = key_q[15:8];
            default: kb = key_q[7:0];
          endcase
          r.kind   = wsdu_pkg::KindData;
          r.fin    = fin_q;
          r.opcode = op_q;
          r.plen   = len_q[wsdu_pkg::LenW-1:0];
          r.data   = b ^ kb;
          r.last   = ({33'd0, idx_q} + 64'd1 >= len_q);
          idx_q    = idx_q + 1'b1;
          if (r.last) begin
            ph    = wsdu_pkg::PhHdr0;
            idx_q = '0;
          end
          due_results.push_back(r);
        end
        default: ph = wsdu_pkg::PhHdr0;
      endcase
    endfunction

    function void report(string what, ws_result_t want, ws_result_t got);
      failures++;
      if (shown < 10) begin
        $display("%s: expected kind=%0d fin=%0d op=%0d len=%0d data=%02h last=%0d err=%0d",
                 what, want.kind, want.fin, want.opcode, want.plen, want.data, want.last,
                 want.code);
        $display("    got      kind=%0d fin=%0d op=%0d len=%0d data=%02h last=%0d err=%0d",
                 got.kind, got.fin, got.opcode, got.plen, got.data, got.last, got.code);
      end
      shown++;
    endfunction

    function void check_result(logic [wsdu_pkg::OutTuserW-1:0] user,
                               logic [wsdu_pkg::OutTdataW-1:0] tdata, logic tlast);
      ws_result_t want;
      ws_result_t got;
      logic       bad;
      got.kind   = wsdu_pkg::kind_e'(user);
      got.fin    = tdata[0];
      got.opcode = tdata[4:1];
      got.plen   = tdata[35:5];
      got.data   = tdata[43:36];
      got.last   = tlast;
      got.code   = wsdu_pkg::err_code_e'(tdata[46:44]);
      if (due_results.size() == 0) begin
        report("unexpected result", '0, got);
        return;
      end
      want = due_results.pop_front();
      bad  = (got.kind !== want.kind) || (got.fin !== want.fin) ||
             (got.opcode !== want.opcode) || (got.plen !== want.plen) ||
             (got.data !== want.data) || (got.last !== want.last) ||
             (got.code !== want.code);
      if (bad) report("mismatch", want, got);
    endfunction
  endclass

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           cfg_wr_en_i;
  logic [wsdu_pkg::LenW-1:0]      cfg_wr_data_i;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  logic [wsdu_pkg::ByteW-1:0]     s_axis_tdata;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready;
  logic [wsdu_pkg::OutTdataW-1:0] m_axis_tdata;
  logic [wsdu_pkg::OutTuserW-1:0] m_axis_tuser;
  logic                           m_axis_tlast;

  frame_tracker tracker;
  int unsigned  bytes_taken = 0;
  int unsigned  cur_max     = wsdu_pkg::MaxLenReset;
  logic         calm        = 1'b0;
  logic         hold_req    = 1'b0;

  websocket_frame_deframer_unmask i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_wr_en_i  (cfg_wr_en_i),
    .cfg_wr_data_i(cfg_wr_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #1 clk_i = ~clk_i;

  task automatic push_byte(input logic [wsdu_pkg::ByteW-1:0] b);
    if (!calm && $urandom_range(0, 99) < 33) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    tracker.take_byte(b);
    bytes_taken++;
  endtask

  task automatic send_frame(input logic fin, input logic [wsdu_pkg::OpW-1:0] op,
                            input logic [63:0] len, input len_enc_e enc,
                            input int unsigned nbytes);
    logic [31:0] key;
    key = $urandom;
    push_byte({fin, 3'b000, op});
    case (enc)
      EncShort: push_byte({1'b1, len[6:0]});
      Enc16: begin
        push_byte({1'b1, wsdu_pkg::LenExt16});
        push_byte(len[15:8]);
        push_byte(len[7:0]);
      end
      default: begin
        push_byte({1'b1, wsdu_pkg::LenExt64});
        for (int i = 7; i >= 0; i--) push_byte(len[8*i +: 8]);
      end
    endcase
    for (int i = 3; i >= 0; i--) push_byte(key[8*i +: 8]);
    for (int unsigned n = 0; n < nbytes; n++) push_byte(8'($urandom_range(0, 255)));
  endtask

  function automatic len_enc_e pick_enc(int unsigned len);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (len >= 126) return (r < 5) ? Enc16 : Enc64;
    if (r < 8) return EncShort;
    return (r == 8) ? Enc16 : Enc64;
  endfunction

  // Well-formed frame with a known opcode and a length within the limit.
  task automatic random_frame();
    logic [wsdu_pkg::OpW-1:0] op;
    logic                     fin;
    int unsigned              cap;
    int unsigned              len;
    int unsigned              r;
    case ($urandom_range(0, 5))
      0:       op = wsdu_pkg::OpCont;
      1:       op = wsdu_pkg::OpText;
      2:       op = wsdu_pkg::OpBin;
      3:       op = wsdu_pkg::OpClose;
      4:       op = wsdu_pkg::OpPing;
      default: op = wsdu_pkg::OpPong;
    endcase
    fin = op[3] ? 1'b1 : 1'($urandom_range(0, 1));
    cap = (cur_max < 300) ? cur_max : 300;
    if (op[3] && cap > 125) cap = 125;
    r = $urandom_range(0, 99);
    if (r < 60) len = $urandom_range(0, 12);
    else if (r < 85) len = $urandom_range(13, 60);
    else if (r < 95) len = $urandom_range(120, 130);
    else len = $urandom_range(126, 300);
    if (len > cap) len = $urandom_range(0, cap);
    send_frame(fin, op, 64'(len), pick_enc(len), len);
  endtask

  task automatic wait_idle();
    // stop offering so that no byte is taken twice while waiting
    s_axis_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    // the parser may still hold a header in progress that owes nothing yet
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_max(input int unsigned v);
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= wsdu_pkg::LenW'(v);
    @(posedge clk_i);
    cfg_wr_en_i     <= 1'b0;
    tracker.max_len  = wsdu_pkg::LenW'(v);
    cur_max          = v;
  endtask

  task automatic close_with_error();
    int unsigned r;
    case ($urandom_range(0, 6))
      0: push_byte({1'b1, 3'($urandom_range(1, 7)), wsdu_pkg::OpText});
      1: begin
        push_byte({1'b1, 3'b000, wsdu_pkg::OpBin});
        push_byte({1'b0, 7'($urandom_range(0, 127))});
      end
      2: send_frame(1'b1, wsdu_pkg::OpBin, 64'(cur_max + 1), Enc16, 4);
      3: send_frame(1'b1, wsdu_pkg::OpText,
                    {32'($urandom), 32'($urandom)} | 64'h8000_0000, Enc64, 4);
      4: begin
        r = $urandom_range(0, 9);
        send_frame(1'b1, (r < 5) ? 4'(3 + r) : 4'(6 + r), 64'd0, EncShort, 0);
      end
      5: send_frame(1'b0, wsdu_pkg::OpPing, 64'($urandom_range(0, 10)), EncShort, 2);
      default: send_frame(1'b1, wsdu_pkg::OpClose, 64'd126, Enc16, 2);
    endcase
    // halted: drop everything from here on
    repeat (20) push_byte(8'($urandom_range(0, 255)));
  endtask

  initial begin : result_sink
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (80) @(posedge clk_i);
      end else begin
        m_axis_tready <= calm || ($urandom_range(0, 99) >= 33);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      tracker.check_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);
    end
  end

  initial begin : stimulus
    int unsigned mid_max;
    int          guard;
    tracker = new();
    rst_ni        <= 1'b0;
    cfg_wr_en_i   <= 1'b0;
    cfg_wr_data_i <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty frame, fragment, both extended length forms
    send_frame(1'b1, wsdu_pkg::OpClose, 64'd0, EncShort, 0);
    send_frame(1'b0, wsdu_pkg::OpText, 64'd5, EncShort, 5);
    send_frame(1'b1, wsdu_pkg::OpCont, 64'd2, Enc16, 2);
    send_frame(1'b1, wsdu_pkg::OpBin, 64'd1, Enc64, 1);
    while (bytes_taken < 350) random_frame();

    wait_idle();
    write_max(32'h7fff_ffff);
    calm = 1'b1;
    send_frame(1'b1, wsdu_pkg::OpPing, 64'd125, EncShort, 125);
    while (bytes_taken < 600) random_frame();
    calm = 1'b0;
    while (bytes_taken < 750) random_frame();

    // hold the sink off while a long frame keeps coming, then drain fully
    hold_req = 1'b1;
    send_frame(1'b1, wsdu_pkg::OpBin, 64'd48, EncShort, 48);
    wait_idle();

    write_max(0);
    repeat (12) random_frame();

    wait_idle();
    mid_max = $urandom_range(130, 300);
    write_max(mid_max);
    send_frame(1'b1, wsdu_pkg::OpPong, 64'd125, Enc64, 125);
    send_frame(1'b0, wsdu_pkg::OpBin, 64'(mid_max), Enc16, mid_max);
    while (bytes_taken < 1400) random_frame();

    close_with_error();
    s_axis_tvalid <= 1'b0;

    for (guard = 0; guard < 4000 && tracker.pending() != 0; guard++) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    tracker.failures += tracker.pending();
    if (tracker.failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #400000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire
